### src/bfd_pkg.sv
// Shared constants and types for the box filter downscaler.
`timescale 1ns / 1ps
package bfd_pkg;

    localparam int MAX_SRC = 1024;
    localparam int MAX_TGT = 256;
    localparam int SW_W    = 11;
    localparam int TW_W    = 9;
    localparam int POS_W   = 10;
    localparam int TX_W    = 8;
    localparam int BND_W   = 13;
    localparam int SUM_W   = 28;
    localparam int CNT_W   = 21;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int CH_W    = 8;

    typedef struct packed {
        logic [31:0]     pixel;
        logic [TX_W-1:0] col;
        logic [TX_W-1:0] row;
        logic            emit;
        logic            last;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] a;
        logic [CNT_W-1:0] cnt;
    } acc_t;

endpackage

### src/bfd_front.sv
// Front end: configuration registers, window tracking and pixel classification.
`timescale 1ns / 1ps
module bfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              restart,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    output logic              push,
    output bfd_pkg::item_t    push_item,
    input  logic              q_full
);
    import bfd_pkg::*;

    localparam logic [1:0] REG_SW = 2'd0;
    localparam logic [1:0] REG_SH = 2'd1;
    localparam logic [1:0] REG_TW = 2'd2;
    localparam logic [1:0] REG_TH = 2'd3;

    logic [SW_W-1:0] sw_reg, sh_reg;
    logic [TW_W-1:0] tw_reg, th_reg;
    logic [POS_W-1:0] sx_reg, sy_reg;
    logic [TX_W-1:0]  x_reg, y_reg;
    logic signed [BND_W-1:0] d_reg, e_reg;

    logic [SW_W-1:0] sw_eff, sh_eff;
    logic [TW_W-1:0] tw_c, th_c, tw_eff, th_eff;
    logic signed [BND_W-1:0] d_cur, e_cur, sw_s, sh_s, tw_s, th_s;
    logic col_close, row_close, row_wrap, frame_wrap, wr;

    function automatic logic [SW_W-1:0] clamp_src(input logic [SW_W-1:0] v);
        if (v == '0)
            return SW_W'(1);
        else if (v > SW_W'(MAX_SRC))
            return SW_W'(MAX_SRC);
        else
            return v;
    endfunction

    function automatic logic [TW_W-1:0] clamp_tgt(input logic [TW_W-1:0] v);
        if (v == '0)
            return TW_W'(1);
        else if (v > TW_W'(MAX_TGT))
            return TW_W'(MAX_TGT);
        else
            return v;
    endfunction

    assign wr = psel && penable && pwrite;
    assign restart = wr;

    always_comb
    begin
        case (paddr[3:2])
            REG_SW:  prdata = {{(32-SW_W){1'b0}}, sw_reg};
            REG_SH:  prdata = {{(32-SW_W){1'b0}}, sh_reg};
            REG_TW:  prdata = {{(32-TW_W){1'b0}}, tw_reg};
            REG_TH:  prdata = {{(32-TW_W){1'b0}}, th_reg};
            default: prdata = '0;
        endcase
    end

    always_comb
    begin
        sw_eff = clamp_src(sw_reg);
        sh_eff = clamp_src(sh_reg);
        tw_c   = clamp_tgt(tw_reg);
        th_c   = clamp_tgt(th_reg);
        tw_eff = ({2'b0, tw_c} > sw_eff) ? sw_eff[TW_W-1:0] : tw_c;
        th_eff = ({2'b0, th_c} > sh_eff) ? sh_eff[TW_W-1:0] : th_c;
        sw_s = $signed({2'b0, sw_eff});
        sh_s = $signed({2'b0, sh_eff});
        tw_s = $signed({4'b0, tw_eff});
        th_s = $signed({4'b0, th_eff});
        // window end test kept as (s+2)*t - (x+1)*S, positive when the window closes
        d_cur = (sx_reg == '0) ? (tw_s + tw_s - sw_s) : d_reg;
        e_cur = (sy_reg == '0) ? (th_s + th_s - sh_s) : e_reg;
        col_close  = d_cur > 0;
        row_close  = e_cur > 0;
        row_wrap   = ({1'b0, sx_reg} + SW_W'(1)) >= sw_eff;
        frame_wrap = ({1'b0, sy_reg} + SW_W'(1)) >= sh_eff;
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        push_item.pixel = s_tdata;
        push_item.col   = x_reg;
        push_item.row   = y_reg;
        push_item.emit  = col_close && row_close;
        push_item.last  = col_close && row_close
                          && (({1'b0, x_reg} + TW_W'(1)) == tw_eff)
                          && (({1'b0, y_reg} + TW_W'(1)) == th_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= SW_W'(1);
            sh_reg <= SW_W'(1);
            tw_reg <= TW_W'(1);
            th_reg <= TW_W'(1);
            sx_reg <= '0;
            sy_reg <= '0;
            x_reg  <= '0;
            y_reg  <= '0;
            d_reg  <= '0;
            e_reg  <= '0;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_SW:  sw_reg <= pwdata[SW_W-1:0];
                REG_SH:  sh_reg <= pwdata[SW_W-1:0];
                REG_TW:  tw_reg <= pwdata[TW_W-1:0];
                REG_TH:  th_reg <= pwdata[TW_W-1:0];
                default: ;
            endcase
            sx_reg <= '0;
            sy_reg <= '0;
            x_reg  <= '0;
            y_reg  <= '0;
        end
        else if (push)
        begin
            if (row_wrap)
            begin
                sx_reg <= '0;
                x_reg  <= '0;
                if (frame_wrap)
                begin
                    sy_reg <= '0;
                    y_reg  <= '0;
                end
                else
                begin
                    sy_reg <= sy_reg + POS_W'(1);
                    if (row_close)
                    begin
                        y_reg <= y_reg + TX_W'(1);
                        e_reg <= e_cur + th_s - sh_s;
                    end
                    else
                        e_reg <= e_cur + th_s;
                end
            end
            else
            begin
                sx_reg <= sx_reg + POS_W'(1);
                if (col_close)
                begin
                    x_reg <= x_reg + TX_W'(1);
                    d_reg <= d_cur + tw_s - sw_s;
                end
                else
                    d_reg <= d_cur + tw_s;
            end
        end
    end

endmodule

### src/bfd_queue.sv
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps
module bfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bfd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bfd_pkg::item_t head_item
);
    import bfd_pkg::*;

    item_t slots [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, rp_reg;
    logic [Q_AW:0]   cnt_reg;

    assign full       = cnt_reg == (Q_AW+1)'(Q_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_item  = slots[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wp_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + Q_AW'(1);
            if (pop)
                rp_reg <= rp_reg + Q_AW'(1);
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (Q_AW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (Q_AW+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

### src/bfd_back.sv
// Back end: column accumulator memory, per-window divider and output register.
`timescale 1ns / 1ps
module bfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           restart,
    input  logic           head_valid,
    input  bfd_pkg::item_t head_item,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [47:0]    m_tdata,
    output logic           m_tlast
);
    import bfd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RMW  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    acc_t   mem [MAX_TGT];
    logic [MAX_TGT-1:0] valid_reg;
    acc_t   rd_reg, acc_sum;
    logic   hit_reg;
    item_t  cur_reg;
    logic [SUM_W-1:0] rem_reg [4];
    logic [SUM_W-1:0] rem_in [4];
    logic [CH_W-1:0]  quo_reg [4];
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]       step_reg;
    logic [SUM_W-1:0] div_trial;

    assign pop = (state_reg == ST_IDLE) && head_valid;

    always_comb
    begin
        acc_sum   = hit_reg ? rd_reg : '0;
        acc_sum.r = acc_sum.r + SUM_W'(cur_reg.pixel[31:24]);
        acc_sum.g = acc_sum.g + SUM_W'(cur_reg.pixel[23:16]);
        acc_sum.b = acc_sum.b + SUM_W'(cur_reg.pixel[15:8]);
        acc_sum.a = acc_sum.a + SUM_W'(cur_reg.pixel[7:0]);
        acc_sum.cnt = acc_sum.cnt + CNT_W'(1);
        div_trial = {{(SUM_W-CNT_W){1'b0}}, cnt_reg} << step_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (head_valid) state_next = ST_RMW;
            ST_RMW:  state_next = cur_reg.emit ? ST_DIV : ST_IDLE;
            ST_DIV:  if (step_reg == 3'd0) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // read the column entry as the beat leaves the queue
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_item;
            rd_reg  <= mem[head_item.col];
            hit_reg <= valid_reg[head_item.col];
        end
        if (state_reg == ST_RMW && !cur_reg.emit)
            mem[cur_reg.col] <= acc_sum;
    end

    always_comb
    begin
        rem_in[0] = acc_sum.r;
        rem_in[1] = acc_sum.g;
        rem_in[2] = acc_sum.b;
        rem_in[3] = acc_sum.a;
    end

    // restoring division, one quotient bit per cycle on all four channels
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RMW)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rem_reg[i] <= rem_in[i];
                quo_reg[i] <= '0;
            end
            cnt_reg  <= acc_sum.cnt;
            step_reg <= 3'd7;
        end
        else if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (rem_reg[i] >= div_trial)
                begin
                    rem_reg[i] <= rem_reg[i] - div_trial;
                    quo_reg[i][step_reg] <= 1'b1;
                end
            end
            step_reg <= step_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
                valid_reg <= '0;
            else if (state_reg == ST_RMW)
                valid_reg[cur_reg.col] <= !cur_reg.emit;
        end
    end

    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {cur_reg.row, cur_reg.col,
                       quo_reg[0], quo_reg[1], quo_reg[2], quo_reg[3]};
    assign m_tlast  = cur_reg.last;

endmodule

### src/box_filter_image_downscale.sv
// Top level of the area-average image downscaler.
`timescale 1ns / 1ps
// Source RGBA8 pixels enter in raster order, one beat per pixel, and each
// destination pixel leaves as one beat once the last source pixel of its
// window has arrived. The front end takes a pixel every cycle into a four
// beat queue unless the queue is full; the back end pops a pixel in its idle
// state and updates the column accumulator memory in its read-modify-write
// state, and takes no new pixel before that update. A pixel that closes a
// window then goes through the bit-serial divider and the output handshake.
// Any register write restarts the frame; write only while the block is idle.
module box_filter_image_downscale (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // source_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_pixel, result_column, result_row
    output logic        m_tlast    // frame_done
);
    import bfd_pkg::*;

    logic  restart, push, q_full, pop, head_valid;
    item_t push_item, head_item;

    assign pready = 1'b1;

    bfd_front u_front (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .restart, .s_tvalid, .s_tready, .s_tdata,
        .push, .push_item, .q_full
    );

    bfd_queue u_queue (
        .clk, .rst_n, .push, .push_item, .full(q_full),
        .pop, .head_valid, .head_item
    );

    bfd_back u_back (
        .clk, .rst_n, .restart, .head_valid, .head_item, .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

endmodule

### tb/tb_box_filter_image_downscale.sv
// Testbench for the area-average image downscaler: directed table plus random frames.
`timescale 1ns / 1ps
module tb_box_filter_image_downscale;
    import bfd_pkg::*;

    localparam int ADDR_SW = 0;
    localparam int ADDR_SH = 4;
    localparam int ADDR_TW = 8;
    localparam int ADDR_TH = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] pixel;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        last;
    } dst_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // source_pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // result_pixel, result_column, result_row
    logic        m_tlast;   // frame_done

    box_filter_image_downscale dut (.*);

    // predictor state
    int unsigned cfg_sw, cfg_sh, cfg_tw, cfg_th;
    int unsigned sum_r [MAX_TGT];
    int unsigned sum_g [MAX_TGT];
    int unsigned sum_b [MAX_TGT];
    int unsigned sum_a [MAX_TGT];
    int unsigned cnt   [MAX_TGT];
    int unsigned src_x, src_y, dst_x, dst_y, col_step, row_step;

    dst_pixel_t  averaged_q[$];
    int          mismatches;
    int          results_seen;
    int          pixels_sent;
    int          idle_cycles;
    int          frames_seen;
    bit          hold_sink;
    bit          timed_out;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < MAX_TGT; i++)
        begin
            sum_r[i] = 0; sum_g[i] = 0; sum_b[i] = 0; sum_a[i] = 0; cnt[i] = 0;
        end
        src_x = 0; src_y = 0; dst_x = 0; dst_y = 0; col_step = 0; row_step = 0;
    endfunction

    // accumulate one source pixel, queue the averaged pixel when a window closes
    function automatic void predict_average(logic [31:0] p);
        int unsigned sw, sh, tw, th, tx, col_end, row_end, c;
        dst_pixel_t  d;
        sw = clamp_dim(cfg_sw, MAX_SRC);
        sh = clamp_dim(cfg_sh, MAX_SRC);
        tw = clamp_dim(cfg_tw, MAX_TGT);
        th = clamp_dim(cfg_th, MAX_TGT);
        if (tw > sw)
            tw = sw;
        if (th > sh)
            th = sh;
        tx = dst_x % MAX_TGT;
        sum_r[tx] += p[31:24];
        sum_g[tx] += p[23:16];
        sum_b[tx] += p[15:8];
        sum_a[tx] += p[7:0];
        cnt[tx]   += 1;
        col_end = (col_step + sw) / tw;
        row_end = (row_step + sh) / th;
        if (src_x + 1 >= col_end)
        begin
            if (src_y + 1 >= row_end)
            begin
                c = (cnt[tx] != 0) ? cnt[tx] : 1;
                d.pixel = {8'(sum_r[tx] / c), 8'(sum_g[tx] / c),
                           8'(sum_b[tx] / c), 8'(sum_a[tx] / c)};
                d.col  = 8'(tx);
                d.row  = 8'(dst_y);
                d.last = (tx + 1 == tw) && (dst_y + 1 == th);
                averaged_q.push_back(d);
                sum_r[tx] = 0; sum_g[tx] = 0; sum_b[tx] = 0; sum_a[tx] = 0; cnt[tx] = 0;
            end
            dst_x += 1;
            col_step += sw;
        end
        src_x += 1;
        if (src_x >= sw)
        begin
            src_x = 0; dst_x = 0; col_step = 0;
            src_y += 1;
            if (src_y >= row_end)
            begin
                dst_y += 1;
                row_step += sh;
            end
            if (src_y >= sh)
            begin
                src_y = 0; dst_y = 0; row_step = 0;
            end
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input int addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 4'(addr);
        pwdata  <= value;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_SW: cfg_sw = value & 32'h7FF;
            ADDR_SH: cfg_sh = value & 32'h7FF;
            ADDR_TW: cfg_tw = value & 32'h1FF;
            ADDR_TH: cfg_th = value & 32'h1FF;
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic set_sizes(input int sw, input int sh, input int tw, input int th);
        write_reg(ADDR_SW, sw);
        write_reg(ADDR_SH, sh);
        write_reg(ADDR_TW, tw);
        write_reg(ADDR_TH, th);
    endtask

    // send one pixel, leaving tvalid up when the next beat follows directly
    task automatic send_pixel(input logic [31:0] p, input bit use_gaps);
        int g;
        g = use_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
            @(posedge clk);
        while (!s_tready);
        predict_average(p);
        pixels_sent++;
    endtask

    task automatic drain();
        // drop tvalid right after the last accepted beat
        s_tvalid <= 1'b0;
        while (averaged_q.size() != 0 && !timed_out)
            @(posedge clk);
        // a pixel that closes no window may still be in the pipeline
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_frame(input int n_frames);
        int total;
        total = clamp_dim(cfg_sw, MAX_SRC) * clamp_dim(cfg_sh, MAX_SRC) * n_frames;
        for (int i = 0; i < total; i++)
            send_pixel(rand_pixel(), 1'b1);
    endtask

    // receiver: random stalls, occasional long hold-off
    initial
    begin
        int g;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dst_pixel_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tlast)
                frames_seen++;
            if (averaged_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat pixel=%h col=%0d row=%0d",
                             m_tdata[31:0], m_tdata[39:32], m_tdata[47:40]);
            end
            else
            begin
                e = averaged_q.pop_front();
                if (m_tdata[31:0] !== e.pixel || m_tdata[39:32] !== e.col ||
                    m_tdata[47:40] !== e.row || m_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h c%0d r%0d l%b, got %h c%0d r%0d l%b",
                                 e.pixel, e.col, e.row, e.last, m_tdata[31:0],
                                 m_tdata[39:32], m_tdata[47:40], m_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            timed_out = 1'b1;
            $display("box_filter_image_downscale verification failed");
            $finish;
        end
    end

    typedef struct {
        int          sw, sh, tw, th;  // -1 leaves the setting as it is
        logic [31:0] pixel;
        bit          check_fixed;
        logic [31:0] fixed_pixel;
    } stim_row_t;

    stim_row_t directed[] = '{
        // after reset 1x1 -> 1x1: pixel passes through
        '{-1, -1, -1, -1, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{-1, -1, -1, -1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{-1, -1, -1, -1, 32'h1234_5678, 1'b1, 32'h1234_5678},
        // zero sizes clamp to one
        '{0, 0, 0, 0, 32'hA5A5_5A5A, 1'b1, 32'hA5A5_5A5A},
        // 2x1 -> 1x1: channel averages truncate
        '{2, 1, 1, 1, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{-1, -1, -1, -1, 32'h0000_0001, 1'b1, 32'h7F7F_7F80},
        // target larger than source clamps down
        '{3, 2, 9, 9, 32'h0102_0304, 1'b0, 32'h0},
        '{-1, -1, -1, -1, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{-1, -1, -1, -1, 32'h8080_8080, 1'b0, 32'h0},
        '{-1, -1, -1, -1, 32'h0000_0000, 1'b0, 32'h0},
        '{-1, -1, -1, -1, 32'h7F7F_7F7F, 1'b0, 32'h0},
        '{-1, -1, -1, -1, 32'hDEAD_BEEF, 1'b0, 32'h0},
        // uneven 5x3 -> 2x2 windows
        '{5, 3, 2, 2, 32'hFFFF_FFFF, 1'b0, 32'h0}
    };

    initial
    begin
        dst_pixel_t d;
        int stall;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        mismatches = 0; results_seen = 0; pixels_sent = 0; frames_seen = 0;
        idle_cycles = 0; hold_sink = 1'b0; timed_out = 1'b0;
        cfg_sw = 1; cfg_sh = 1; cfg_tw = 1; cfg_th = 1;
        restart_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].sw >= 0)
            begin
                drain();
                set_sizes(directed[i].sw, directed[i].sh, directed[i].tw, directed[i].th);
            end
            send_pixel(directed[i].pixel, 1'b0);
            if (directed[i].check_fixed && averaged_q.size() != 0)
            begin
                d = averaged_q[$];
                if (d.pixel !== directed[i].fixed_pixel)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: predictor %h, table %h",
                                 i, d.pixel, directed[i].fixed_pixel);
                end
            end
        end
        run_frame(1);
        drain();

        // rewrite the target height through its address; the frame restarts
        write_reg(4'hC + 0, 32'h3);
        // oversized width clamps to 1024 and 256: first part of the row
        set_sizes(2047, 1, 511, 1);
        for (int i = 0; i < 300; i++)
            send_pixel(rand_pixel(), 1'b1);
        drain();
        // oversized height clamps the same way: first part of the column
        set_sizes(1, 2047, 1, 511);
        for (int i = 0; i < 300; i++)
            send_pixel(rand_pixel(), 1'b1);
        drain();
        set_sizes(1, 4, 1, 4);
        run_frame(2);
        drain();

        // long receiver hold-off while the sender keeps offering
        set_sizes(1, 1, 1, 1);
        hold_sink = 1'b1;
        fork
            begin
                stall = $urandom_range(200, 400);
                repeat (stall) @(posedge clk);
                hold_sink = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_pixel($urandom, 1'b0);
            end
        join
        drain();

        // random frames, mostly small sizes
        while (pixels_sent < 900 && !timed_out)
        begin
            int sw, sh;
            sw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
            sh = $urandom_range(1, 8);
            set_sizes(sw, sh, $urandom_range(1, sw), $urandom_range(1, sh));
            run_frame($urandom_range(1, 3));
            drain();
        end

        // last setting: full target height over an uneven row split
        set_sizes(2, 300, 2, 256);
        run_frame(1);
        drain();

        $display("sent %0d source pixels, checked %0d averaged pixels over %0d frames",
                 pixels_sent, results_seen, frames_seen);
        $display("covered clamped and oversized sizes, uneven windows, long output stalls");
        if (mismatches == 0 && averaged_q.size() == 0)
            $display("box_filter_image_downscale verification clean");
        else
            $display("box_filter_image_downscale verification failed");
        $finish;
    end

endmodule

### filelist.f
src/bfd_pkg.sv
src/bfd_front.sv
src/bfd_queue.sv
src/bfd_back.sv
src/box_filter_image_downscale.sv
tb/tb_box_filter_image_downscale.sv
